/* rtl/bds_pkg.sv */
// Package with the word types, segment descriptor and constants of the brush dab spacer.
package bds_pkg;

	localparam int FRAC_BITS    = 8;
	localparam int COORD_W      = 24;
	localparam int DELTA_W      = 25;
	localparam int LEN_W        = 25;
	localparam int T_W          = 26;
	localparam int SPACING_W    = 16;
	localparam int EMIT_W       = 7;
	localparam int MAX_DABS_DEF = 64;
	localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(1 << FRAC_BITS);

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      stroke_start;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] dab_x;
		logic signed [COORD_W-1:0] dab_y;
		logic                      last_dab;
		logic                      clipped;
	} dab_t;

	// One segment that still has dabs to place.
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic [LEN_W-1:0]          len;
		logic [SPACING_W-1:0]      t0;
		logic [SPACING_W-1:0]      spacing;
		logic [EMIT_W-1:0]         emit;
		logic                      clip;
	} seg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

/* rtl/brush_dab_spacer.sv */
// Top level of the brush dab spacer: configuration register, front end, queue, back end.
//
//   channel | direction | handshake        | word
//   --------+-----------+------------------+--------------------------------------
//   in      | in        | in_valid/stall   | point_t: point_x, point_y, stroke_start
//   out     | out       | out_valid/stall  | dab_t: dab_x, dab_y, last_dab, clipped
//   cfg     | in        | cfg_valid/ready  | dab_spacing, 16 bits
//
// A stroke start or an anchor-only point only sets the anchor. A segment point holds the
// input through the squares, a 25-step root, and a 26-step divide in the front.
// Each dab is then computed in the back end by the two 25-step dividers.
// Reset clears the anchor, the carried distance and the queue; spacing returns to 256.
// The queue holds two segments, so the front keeps measuring while the output stalls.
module brush_dab_spacer #(
	parameter int MAX_DABS = bds_pkg::MAX_DABS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bds_pkg::point_t in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output bds_pkg::dab_t   out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);
	import bds_pkg::*;

	logic [SPACING_W-1:0] spacing_q;
	logic                 push, pop;
	seg_t                 seg_w, seg_r;
	q_stat_t              qstat;

	// The spacing register takes a write on every cycle; writes must come only while idle (not enforced here).
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			spacing_q <= cfg_data;
		end
	end

	bds_front #(.MAX_DABS(MAX_DABS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .spacing(spacing_q), .push(push), .seg(seg_w), .qstat(qstat)
	);

	bds_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(seg_w), .pop(pop),
		.rdata(seg_r), .stat(qstat)
	);

	// The back end owns the output word register, which holds still while stalled.
	bds_back u_back (
		.clk(clk), .arst_n(arst_n), .head(seg_r), .qstat(qstat), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

/* rtl/bds_div.sv */
// Restoring divider, one quotient bit per cycle; the upper numerator part must be below the divisor.
module bds_div #(
	parameter int WD = 16,
	parameter int WQ = 26
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [WQ+WD-1:0] num,
	input  logic [WD-1:0]  den,
	output logic           done,
	output logic [WQ-1:0]  quo,
	output logic [WD-1:0]  rem
);
	localparam int CW = $clog2(WQ + 1);

	logic [WD-1:0] rem_q;
	logic [WQ-1:0] quo_q;
	logic [WD-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [WD:0]   trial;
	logic          ge;

	assign trial = {rem_q, quo_q[WQ-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(WQ - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[WQ+WD-1:WQ];
			quo_q <= num[WQ-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? WD'(trial - {1'b0, den_q}) : trial[WD-1:0];
			quo_q <= {quo_q[WQ-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

/* rtl/bds_front.sv */
// Front end: takes points, keeps the anchor and carried distance, measures segments.
module bds_front #(
	parameter int MAX_DABS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bds_pkg::point_t in_data,
	input  logic [15:0]     spacing,
	output logic            push,
	output bds_pkg::seg_t   seg,
	input  bds_pkg::q_stat_t qstat
);
	import bds_pkg::*;

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_SQ   = 3'd1;
	localparam logic [2:0] F_ROOT = 3'd2;
	localparam logic [2:0] F_PREP = 3'd3;
	localparam logic [2:0] F_DIV  = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;
	localparam logic [2:0] F_RAD  = 3'd6;

	logic [2:0]                st_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, seg_px_q, seg_py_q;
	logic                      have_q;
	logic [SPACING_W-1:0]      carried_q, sp_q, t0_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [47:0]               sqx_q, sqy_q;
	logic [49:0]               rad_q;
	logic [25:0]               rrem_q;
	logic [LEN_W-1:0]          root_q;
	logic [4:0]                it_q;
	logic [EMIT_W-1:0]         emit_q;
	logic                      clip_q;
	logic                      accept;
	logic signed [DELTA_W-1:0] dx_n, dy_n;
	logic [23:0]               magx, magy;
	logic [27:0]               rem2, trial;
	logic                      ge;
	logic [SPACING_W-1:0]      sp_n, cm_n;
	logic                      div_start, div_done;
	logic [25:0]               div_quo;
	logic [15:0]               div_rem;
	logic [41:0]               div_num;

	assign accept = in_valid && !in_stall;
	assign in_stall = st_q != F_IDLE;
	assign dx_n = DELTA_W'(in_data.point_x) - DELTA_W'(prev_x_q);
	assign dy_n = DELTA_W'(in_data.point_y) - DELTA_W'(prev_y_q);
	assign magx = dx_q[DELTA_W-1] ? 24'(-dx_q) : dx_q[23:0];
	assign magy = dy_q[DELTA_W-1] ? 24'(-dy_q) : dy_q[23:0];

	assign rem2  = {rrem_q, rad_q[49:48]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	assign sp_n = (spacing == '0) ? SPACING_W'(1) : spacing;
	assign cm_n = (carried_q > sp_n) ? sp_n : carried_q;
	assign div_start = st_q == F_PREP;
	assign div_num = {16'd0, 26'(cm_n) + 26'(root_q)};

	bds_div #(.WD(16), .WQ(26)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sp_n), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= F_IDLE;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			have_q    <= 1'b0;
			carried_q <= '0;
			it_q      <= '0;
		end else begin
			unique case (st_q)
				F_IDLE: begin
					if (accept) begin
						prev_x_q <= in_data.point_x;
						prev_y_q <= in_data.point_y;
						have_q   <= 1'b1;
						if (!in_data.stroke_start && have_q) st_q <= F_SQ;
					end
				end
				F_SQ: st_q <= F_RAD;
				F_RAD: begin
					it_q <= '0;
					st_q <= F_ROOT;
				end
				F_ROOT: begin
					it_q <= it_q + 1'b1;
					if (it_q == 5'd24) st_q <= F_PREP;
				end
				F_PREP: begin
					// A zero-length segment leaves the carried distance alone.
					if (root_q == '0) st_q <= F_IDLE;
					else st_q <= F_DIV;
				end
				F_DIV: begin
					if (div_done) begin
						carried_q <= div_rem;
						if (div_quo == '0) st_q <= F_IDLE;
						else st_q <= F_PUSH;
					end
				end
				F_PUSH: if (!qstat.full) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_px_q <= prev_x_q;
			seg_py_q <= prev_y_q;
			dx_q     <= dx_n;
			dy_q     <= dy_n;
		end
		if (st_q == F_SQ) begin
			sqx_q <= magx * magx;
			sqy_q <= magy * magy;
		end
		if (st_q == F_RAD) begin
			rad_q  <= 50'(sqx_q) + 50'(sqy_q);
			rrem_q <= '0;
			root_q <= '0;
		end
		if (st_q == F_ROOT) begin
			rad_q  <= {rad_q[47:0], 2'b00};
			rrem_q <= ge ? 26'(rem2 - trial) : rem2[25:0];
			root_q <= {root_q[LEN_W-2:0], ge};
		end
		if (st_q == F_PREP) begin
			sp_q <= sp_n;
			t0_q <= sp_n - cm_n;
		end
		if (st_q == F_DIV && div_done) begin
			clip_q <= div_quo > 26'(MAX_DABS);
			emit_q <= (div_quo > 26'(MAX_DABS)) ? EMIT_W'(MAX_DABS) : div_quo[EMIT_W-1:0];
		end
	end

	assign push = (st_q == F_PUSH) && !qstat.full;
	assign seg = '{px: seg_px_q, py: seg_py_q, dx: dx_q, dy: dy_q, len: root_q,
		t0: t0_q, spacing: sp_q, emit: emit_q, clip: clip_q};
endmodule

/* rtl/bds_queue.sv */
// Two-entry queue of segment descriptors between the front and back ends.
module bds_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bds_pkg::seg_t    wdata,
	input  logic             pop,
	output bds_pkg::seg_t    rdata,
	output bds_pkg::q_stat_t stat
);
	import bds_pkg::*;

	seg_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign stat  = '{empty: cnt_q == 2'd0, full: cnt_q == 2'd2};
endmodule

/* rtl/bds_back.sv */
// Back end: walks a segment and places its dabs, one word at a time.
module bds_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bds_pkg::seg_t    head,
	input  bds_pkg::q_stat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output bds_pkg::dab_t    out_data
);
	import bds_pkg::*;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_MUL  = 3'd1;
	localparam logic [2:0] B_DIVS = 3'd2;
	localparam logic [2:0] B_DIVW = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]         st_q;
	seg_t               seg_q;
	logic [EMIT_W-1:0]  k_q;
	logic [T_W-1:0]     t_q;
	logic [50:0]        prodx_q, prody_q;
	logic               out_valid_q;
	dab_t               out_q;
	logic [24:0]        magx, magy;
	logic [50:0]        numx, numy;
	logic [25:0]        den;
	logic               dx_done, dy_done;
	logic [24:0]        qx, qy;
	logic [25:0]        rx_unused, ry_unused;
	logic               div_start, out_free, last;
	logic signed [24:0] offx, offy, posx, posy;

	assign magx = seg_q.dx[DELTA_W-1] ? 25'(-seg_q.dx) : 25'(seg_q.dx);
	assign magy = seg_q.dy[DELTA_W-1] ? 25'(-seg_q.dy) : 25'(seg_q.dy);
	assign den  = {seg_q.len, 1'b0};
	assign numx = {prodx_q[49:0], 1'b0} + 51'(seg_q.len);
	assign numy = {prody_q[49:0], 1'b0} + 51'(seg_q.len);
	assign div_start = st_q == B_DIVS;

	bds_div #(.WD(26), .WQ(25)) u_divx (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(numx), .den(den),
		.done(dx_done), .quo(qx), .rem(rx_unused)
	);
	bds_div #(.WD(26), .WQ(25)) u_divy (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(numy), .den(den),
		.done(dy_done), .quo(qy), .rem(ry_unused)
	);

	assign offx = seg_q.dx[DELTA_W-1] ? -$signed(qx) : $signed(qx);
	assign offy = seg_q.dy[DELTA_W-1] ? -$signed(qy) : $signed(qy);
	assign posx = 25'(seg_q.px) + offx;
	assign posy = 25'(seg_q.py) + offy;

	assign out_free = !out_valid_q || !out_stall;
	assign last     = (k_q + 1'b1) == seg_q.emit;
	assign pop      = (st_q == B_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			if (st_q == B_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					k_q <= '0;
					if (!qstat.empty) st_q <= B_MUL;
				end
				B_MUL:  st_q <= B_DIVS;
				B_DIVS: st_q <= B_DIVW;
				B_DIVW: if (dx_done && dy_done) st_q <= B_OUT;
				B_OUT: begin
					if (out_free) begin
						k_q <= k_q + 1'b1;
						st_q <= last ? B_IDLE : B_MUL;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_q <= head;
			t_q   <= T_W'(head.t0);
		end
		if (st_q == B_MUL) begin
			prodx_q <= magx * t_q;
			prody_q <= magy * t_q;
		end
		if (st_q == B_OUT && out_free) begin
			out_q <= '{dab_x: posx[23:0], dab_y: posy[23:0], last_dab: last,
				clipped: seg_q.clip};
			t_q <= t_q + T_W'(seg_q.spacing);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_MUL || st_q == B_OUT) |-> (k_q < seg_q.emit))
		else $error("dab index ran past the segment's dab count");
	a_t_in_seg: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_MUL) |-> (t_q <= T_W'(seg_q.len)))
		else $error("dab offset lies beyond the segment end");
	a_div_pair: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done == dy_done)
		else $error("axis dividers out of step");
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dx_done |-> (st_q == B_DIVW))
		else $error("divider finished outside the wait state");
endmodule
